// ----- design/sha512_pkg.sv -----
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, initial hash values, round constants and sigma functions
// for the SHA-512 engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int unsigned WORD_W = 64;

    // Commands from the message sequencer to the compression core
    typedef struct packed {
        logic push;   // shift one schedule word into the window
        logic start;  // begin compressing the 16 words in the window
        logic init;   // reload the chaining hash with the initial values
    } t_core_cmd;

    localparam logic [WORD_W-1:0] HASH_INIT [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [6:0] LAST_ROUND = 7'd79;

    function automatic logic [WORD_W-1:0] big_sum0(input logic [WORD_W-1:0] x);
        big_sum0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sum1(input logic [WORD_W-1:0] x);
        big_sum1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sum0(input logic [WORD_W-1:0] x);
        small_sum0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sum1(input logic [WORD_W-1:0] x);
        small_sum1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
    endfunction

    function automatic logic [WORD_W-1:0] round_const(input logic [6:0] t);
        logic [WORD_W-1:0] k;
        unique case (t)
            7'd0:  k = 64'h428a2f98d728ae22;
            7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;
            7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;
            7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;
            7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;
            7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;
            7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;
            7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;
            7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;
            7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;
            7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;
            7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;
            7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;
            7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;
            7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;
            7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;
            7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;
            7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;
            7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;
            7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;
            7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;
            7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;
            7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;
            7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;
            7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;
            7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;
            7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;
            7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;
            7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;
            7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;
            7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;
            7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;
            7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;
            7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;
            7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;
            7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;
            7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;
            7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;
            7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;
            7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        round_const = k;
    endfunction

endpackage

// ----- design/sha512_core.sv -----
// ----------------------------------------------------------------------------
// sha512_core
// Compression core: 16-word rolling schedule window, one shared round
// datapath used once per cycle for 80 rounds, then the chaining hash update.
// ----------------------------------------------------------------------------
module sha512_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha512_pkg::t_core_cmd i_cmd,
    input  logic [63:0]         i_word,
    input  logic [2:0]          i_rd_idx,
    output logic [63:0]         o_rd_word,
    output logic                o_busy
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } t_cstate;

    t_cstate     r_state;
    logic [6:0]  r_round;
    logic [63:0] r_win [16];   // r_win[k] holds W[t+k] during round t
    logic [63:0] r_v   [8];    // working variables a..h
    logic [63:0] r_h   [8];    // chaining hash

    logic [63:0] n_sched;
    logic [63:0] n_shift_in;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] ch;
    logic [63:0] maj;

    always_comb begin
        n_sched = sha512_pkg::small_sum1(r_win[14]) + r_win[9]
                + sha512_pkg::small_sum0(r_win[1]) + r_win[0];
        n_shift_in = (r_state == C_IDLE) ? i_word : n_sched;
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + sha512_pkg::big_sum1(r_v[4]) + ch
            + sha512_pkg::round_const(r_round) + r_win[0];
        t2  = sha512_pkg::big_sum0(r_v[0]) + maj;
    end

    assign o_rd_word = r_h[i_rd_idx];
    assign o_busy    = (r_state != C_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_h     <= sha512_pkg::HASH_INIT;
        end else begin
            // window shifts on each loaded word and on every round
            if (i_cmd.push || r_state == C_ROUND) begin
                for (int i = 0; i < 15; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[15] <= n_shift_in;
            end
            unique case (r_state)
                C_IDLE: begin
                    if (i_cmd.init) begin
                        r_h <= sha512_pkg::HASH_INIT;
                    end
                    if (i_cmd.start) begin
                        r_v     <= r_h;
                        r_round <= '0;
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    if (r_round == sha512_pkg::LAST_ROUND) begin
                        r_round <= '0;
                        r_state <= C_ADD;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                C_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_state == C_IDLE)
        else $error("schedule word pushed during compression");

    a_start_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && r_state == C_IDLE) |=> (r_state == C_ROUND && r_round == 7'd0))
        else $error("compression did not start at round zero");

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_ROUND && r_round == sha512_pkg::LAST_ROUND) |=> r_state == C_ADD)
        else $error("hash update missed after final round");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= sha512_pkg::LAST_ROUND)
        else $error("round counter out of range");

endmodule

// ----- design/sha512_digest.sv -----
// A word that does not close a block does not hold the input off; the
// sixteenth word of a block starts a compression that holds the input off until
// it ends (load, 80 rounds on the shared round datapath, then hash update).
// No new word is taken while a block compresses; a last word adds the padding
// words, one or two compressions and 8 digest transactions.
// Reset (sync, active low) loads the initial hash and clears the counters.
// ----------------------------------------------------------------------------
// sha512_digest
// SHA-512 engine: collects message words, pads the message, compresses the
// blocks and streams out the eight digest words.
// ----------------------------------------------------------------------------
module sha512_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] digest_word, [66:64] word_index, rest zero
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_HASH,
        S_OUT
    } t_state;

    t_state      r_state,    n_state;
    logic [3:0]  r_wib,      n_wib;       // words in current block
    logic [60:0] r_bytes,    n_bytes;     // message length in bytes
    logic        r_pad80,    n_pad80;     // full last word: 0x80 word still owed
    logic        r_final,    n_final;     // length fits the current block
    logic        r_out_pend, n_out_pend;  // length word pushed
    logic        r_padding,  n_padding;   // last word seen
    logic [2:0]  r_oidx,     n_oidx;

    sha512_pkg::t_core_cmd core_cmd;
    logic [63:0] push_word;
    logic [63:0] core_word;
    logic        core_busy;

    logic [63:0] in_data;
    logic [3:0]  in_count;
    logic [5:0]  keep_shift;
    logic [63:0] keep_mask;
    logic [63:0] pad_bit;

    assign in_data    = s_axis_tdata[63:0];
    assign in_count   = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
    assign keep_shift = {in_count[2:0], 3'b000};
    assign keep_mask  = ~(64'hFFFF_FFFF_FFFF_FFFF >> keep_shift);
    assign pad_bit    = 64'h8000_0000_0000_0000 >> keep_shift;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_oidx, core_word};
    assign m_axis_tlast  = (r_oidx == 3'd7);

    always_comb begin
        n_state    = r_state;
        n_wib      = r_wib;
        n_bytes    = r_bytes;
        n_pad80    = r_pad80;
        n_final    = r_final;
        n_out_pend = r_out_pend;
        n_padding  = r_padding;
        n_oidx     = r_oidx;
        core_cmd   = '0;
        push_word  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    core_cmd.push = 1'b1;
                    if (s_axis_tlast) begin
                        n_bytes   = r_bytes + 61'(in_count);
                        n_padding = 1'b1;
                        n_state   = S_PAD;
                        if (in_count == 4'd8) begin
                            push_word = in_data;
                            n_pad80   = 1'b1;
                        end else begin
                            push_word = (in_data & keep_mask) | pad_bit;
                            // two words must remain for the 128-bit length
                            if (r_wib <= 4'd13) begin
                                n_final = 1'b1;
                            end
                        end
                    end else begin
                        n_bytes   = r_bytes + 61'd8;
                        push_word = in_data;
                    end
                end
            end
            S_PAD: begin
                core_cmd.push = 1'b1;
                if (r_pad80) begin
                    push_word = 64'h8000_0000_0000_0000;
                    n_pad80   = 1'b0;
                    if (r_wib <= 4'd13) begin
                        n_final = 1'b1;
                    end
                end else if (r_final && r_wib == 4'd15) begin
                    push_word  = {r_bytes, 3'b000};
                    n_out_pend = 1'b1;
                end
            end
            S_HASH: begin
                if (!core_busy) begin
                    priority if (r_out_pend) begin
                        n_state = S_OUT;
                    end else if (r_padding) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    if (r_oidx == 3'd7) begin
                        core_cmd.init = 1'b1;
                        n_oidx        = '0;
                        n_bytes       = '0;
                        n_pad80       = 1'b0;
                        n_final       = 1'b0;
                        n_out_pend    = 1'b0;
                        n_padding     = 1'b0;
                        n_state       = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a full window kicks off a compression
        if (core_cmd.push) begin
            if (r_wib == 4'd15) begin
                core_cmd.start = 1'b1;
                n_wib          = '0;
                n_state        = S_HASH;
                // padding that fills a block leaves room for the length in the next
                if (n_padding) begin
                    n_final = 1'b1;
                end
            end else begin
                n_wib = r_wib + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wib      <= '0;
            r_bytes    <= '0;
            r_pad80    <= 1'b0;
            r_final    <= 1'b0;
            r_out_pend <= 1'b0;
            r_padding  <= 1'b0;
            r_oidx     <= '0;
        end else begin
            r_state    <= n_state;
            r_wib      <= n_wib;
            r_bytes    <= n_bytes;
            r_pad80    <= n_pad80;
            r_final    <= n_final;
            r_out_pend <= n_out_pend;
            r_padding  <= n_padding;
            r_oidx     <= n_oidx;
        end
    end

    sha512_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (core_cmd),
        .i_word    (push_word),
        .i_rd_idx  (r_oidx),
        .o_rd_word (core_word),
        .o_busy    (core_busy)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input taken while digest is being sent");

    a_digest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            |=> (!m_axis_tvalid && r_bytes == 61'd0 && r_wib == 4'd0))
        else $error("engine not cleared after final digest word");

    a_len_in_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_pend |-> (r_final && r_padding && !r_pad80))
        else $error("length pushed outside the final block");

    a_hash_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_cmd.start |=> (r_state == S_HASH && core_busy))
        else $error("sequencer and core out of step on compression");

endmodule

// ----- dv/sha512_digest_tb.sv -----
// ----------------------------------------------------------------------------
// sha512_digest_tb
// Streams messages into the SHA-512 engine and checks every digest word
// against a behavioral SHA-512 hash kept in the bench. Directed messages
// cover empty and short last words, oversized counts and padding that spills
// into an extra block; random messages run in each of four flow-control
// phases. Between phases the sender waits until every digest has come out.
// ----------------------------------------------------------------------------
module sha512_digest_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } t_msg_word;

    typedef struct {
        logic [63:0] digest;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // [63:0] data_word, [67:64] byte_count, rest zero
    logic        s_axis_tlast = 1'b0; // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [71:0] m_axis_tdata;        // [63:0] digest_word, [66:64] word_index, rest zero
    logic        m_axis_tlast;        // last_word

    t_msg_word    word_queue [$];
    t_digest_word digest_due [$];
    t_msg_word    next_word;
    t_digest_word due_word;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           error_count = 0;

    // Behavioral hash state
    logic [63:0] hash_state [8] = IV;
    logic [63:0] sched [16];
    int          fill = 0;
    logic [60:0] byte_total = '0;

    sha512_digest dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic void compress_block();
        logic [63:0] v [8];
        logic [63:0] w, t1, t2, s0, s1;
        v = hash_state;
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                s0 = rotr(sched[(t - 15) % 16], 1) ^ rotr(sched[(t - 15) % 16], 8)
                   ^ (sched[(t - 15) % 16] >> 7);
                s1 = rotr(sched[(t - 2) % 16], 19) ^ rotr(sched[(t - 2) % 16], 61)
                   ^ (sched[(t - 2) % 16] >> 6);
                w = s1 + sched[(t - 7) % 16] + s0 + sched[t % 16];
                sched[t % 16] = w;
            end else begin
                w = sched[t];
            end
            t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
            t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endfunction

    function automatic void load_word(logic [63:0] w);
        sched[fill] = w;
        fill++;
        if (fill == 16) begin
            compress_block();
            fill = 0;
        end
    endfunction

    // Takes one accepted message word; on a last word pads, finishes the hash
    // and queues the eight digest words.
    function automatic void absorb_word(logic [63:0] data, logic [3:0] count, logic last);
        int          n;
        logic [63:0] keep;
        n = (count > 8) ? 8 : count;
        if (!last) begin
            load_word(data);
            byte_total = byte_total + 61'd8;
            return;
        end
        byte_total = byte_total + 61'(n);
        if (n == 8) begin
            load_word(data);
            load_word(64'h80 << 56);
        end else begin
            keep = (n == 0) ? 64'd0 : (~64'd0 << (64 - 8 * n));
            load_word((data & keep) | (64'h80 << (56 - 8 * n)));
        end
        while (fill != 14)
            load_word(64'd0);
        load_word(64'd0);
        load_word({byte_total, 3'b000});
        for (int i = 0; i < 8; i++)
            digest_due.push_back('{hash_state[i], 3'(i), (i == 7)});
        hash_state = IV;
        fill = 0;
        byte_total = '0;
    endfunction

    task automatic send_word(logic [63:0] data, logic [3:0] count, logic last);
        word_queue.push_back('{data, count, last});
    endtask

    task automatic add_message(int n_words);
        logic [63:0] data;
        logic [3:0]  count;
        for (int k = 0; k < n_words; k++) begin
            case ($urandom_range(9))
                0:       data = '1;
                1:       data = '0;
                default: data = {$urandom, $urandom};
            endcase
            if (k == n_words - 1 && $urandom_range(2) == 0)
                count = 4'd8;
            else
                count = 4'($urandom_range(15));
            send_word(data, count, k == n_words - 1);
        end
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word = word_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0000, next_word.count, next_word.data};
                s_axis_tlast  <= next_word.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitors: input side feeds the hash, output side checks digests
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            absorb_word(s_axis_tdata[63:0], s_axis_tdata[67:64], s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_due.size() == 0) begin
                $error("digest transaction with none expected: %h", m_axis_tdata[63:0]);
                error_count++;
            end else begin
                due_word = digest_due.pop_front();
                if (m_axis_tdata[63:0] !== due_word.digest) begin
                    $error("digest_word: expected %h, got %h",
                           due_word.digest, m_axis_tdata[63:0]);
                    error_count++;
                end
                if (m_axis_tdata[66:64] !== due_word.index) begin
                    $error("word_index: expected %0d, got %0d",
                           due_word.index, m_axis_tdata[66:64]);
                    error_count++;
                end
                if (m_axis_tlast !== due_word.last) begin
                    $error("last_word: expected %b, got %b", due_word.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int phase_items;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (phase == 0) begin
                send_word('1, 4'd0, 1'b1);     // empty message, data discarded
                send_word('1, 4'd3, 1'b1);
                send_word('1, 4'd8, 1'b1);
                send_word('0, 4'd15, 1'b1);    // oversized count acts as eight
                // short count on a non-last word is ignored
                send_word(64'h0123456789abcdef, 4'd0, 1'b0);
                send_word(64'h8000000000000001, 4'd9, 1'b1);
                // full last word at position 14: length spills into a second block
                for (int k = 0; k < 14; k++)
                    send_word({$urandom, $urandom}, 4'(k), 1'b0);
                send_word('1, 4'd8, 1'b1);
            end
            phase_items = 0;
            while (phase_items < 25) begin
                int n_words;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: n_words = $urandom_range(8, 1);
                    6, 7:             n_words = $urandom_range(17, 13);
                    8:                n_words = $urandom_range(33, 16);
                    default:          n_words = 1;
                endcase
                add_message(n_words);
                phase_items += n_words;
            end
            // sender holds off until every digest of the phase is out
            while (word_queue.size() != 0 || s_axis_tvalid || digest_due.size() != 0)
                @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && digest_due.size() == 0) begin
            $display("sha512_digest_tb passed");
        end else begin
            $display("sha512_digest_tb failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("sha512_digest_tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sha512_pkg.sv
design/sha512_core.sv
design/sha512_digest.sv
dv/sha512_digest_tb.sv
